>>> rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// opcode and status codes, plus the command and link words shared by the
// timer cells and the top level
// ----------------------------------------------------------------------------
package mct_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_INFO   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_NO_FREE = 2'd2
    } t_status;

    // command broadcast to every cell, op bits already qualified by accept
    typedef struct packed {
        logic        tick;
        logic        create;
        logic        del;
        logic        start;
        logic        stop;
        logic [3:0]  idx;
        logic        periodic;
        logic [31:0] reload;
    } t_cmd;

    // word handed from one cell to the next
    typedef struct packed {
        logic        open;       // no free slot seen yet
        logic [3:0]  claim_idx;  // lowest free slot
        logic        sel_used;   // addressed slot is allocated
        logic [15:0] expired;
        logic [31:0] reload;
        logic        periodic;
        logic [31:0] remaining;
        logic        active;
    } t_link;

endpackage

>>> rtl/multi_channel_countdown_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer
// bank of one-shot / periodic countdown timers built as a row of slot cells
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready   | opcode, index, reload,
//          |           |                           | periodic
//  out     | output    | o_out_valid / i_out_ready | status, new index, mask,
//          |           |                           | info fields, tick count
//
//  one word per cycle: a command is decoded and applied to every cell in the
//  cycle it is accepted, and its response word is registered the same edge
//  the lowest-free search and the info readout ripple through the cell row,
//  so that row sets the critical path
//  o_in_ready drops only while a response word waits and the sink stalls
//  synchronous active-low reset clears allocation, run and mode bits and
//  the global tick count; reload and remaining values need no reset
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer
    import mct_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_timer_index,
    input  logic [31:0] i_reload_tics,
    input  logic        i_periodic,
    // response channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_new_index,
    output logic [15:0] o_expired_mask,
    output logic [31:0] o_info_reload,
    output logic        o_info_periodic,
    output logic [31:0] o_info_remaining,
    output logic        o_info_active,
    output logic [31:0] o_tick_count
);

    logic        accept;
    t_cmd        cmd;
    t_link       link [0:NUM_TIMERS];
    t_link       link_end;

    // response word register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_ticks, n_ticks;
    t_status     r_status, n_status;
    logic [3:0]  r_new_index, n_new_index;
    logic [15:0] r_expired, n_expired;
    logic [31:0] r_info_reload, n_info_reload;
    logic        r_info_periodic, n_info_periodic;
    logic [31:0] r_info_remaining, n_info_remaining;
    logic        r_info_active, n_info_active;

    // a new word is taken whenever the response slot is empty or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // broadcast command, qualified by accept
    always_comb begin
        cmd          = '0;
        cmd.idx      = i_timer_index;
        cmd.periodic = i_periodic;
        cmd.reload   = i_reload_tics;
        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_TICK:   cmd.tick   = 1'b1;
                OP_CREATE: cmd.create = 1'b1;
                OP_DELETE: cmd.del    = 1'b1;
                OP_START:  cmd.start  = 1'b1;
                OP_STOP:   cmd.stop   = 1'b1;
                default:   ;
            endcase
        end
    end

    // head of the chain: search still open, nothing selected
    always_comb begin
        link[0]      = '0;
        link[0].open = 1'b1;
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        mct_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_link  (link[g]),
            .o_link  (link[g+1])
        );
    end

    assign link_end = link[NUM_TIMERS];

    // response word and tick counter
    always_comb begin
        n_out_valid      = r_out_valid && !i_out_ready;
        n_ticks          = r_ticks;
        n_status         = r_status;
        n_new_index      = r_new_index;
        n_expired        = r_expired;
        n_info_reload    = r_info_reload;
        n_info_periodic  = r_info_periodic;
        n_info_remaining = r_info_remaining;
        n_info_active    = r_info_active;
        if (accept) begin
            n_out_valid      = 1'b1;
            n_status         = ST_GOOD;
            n_new_index      = '0;
            n_expired        = '0;
            n_info_reload    = '0;
            n_info_periodic  = 1'b0;
            n_info_remaining = '0;
            n_info_active    = 1'b0;
            case (t_opcode'(i_opcode))
                OP_TICK: begin
                    n_ticks   = r_ticks + 32'd1;
                    n_expired = link_end.expired;
                end
                OP_CREATE: begin
                    if (link_end.open) begin
                        n_status = ST_NO_FREE;
                    end else begin
                        n_new_index = link_end.claim_idx;
                    end
                end
                OP_DELETE, OP_START, OP_STOP: begin
                    if (!link_end.sel_used) begin
                        n_status = ST_BAD_ID;
                    end
                end
                OP_INFO: begin
                    if (!link_end.sel_used) begin
                        n_status = ST_BAD_ID;
                    end else begin
                        n_info_reload    = link_end.reload;
                        n_info_periodic  = link_end.periodic;
                        n_info_remaining = link_end.remaining;
                        n_info_active    = link_end.active;
                    end
                end
                default: ;  // unused opcodes answer good with empty fields
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ticks     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_ticks     <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status         <= n_status;
        r_new_index      <= n_new_index;
        r_expired        <= n_expired;
        r_info_reload    <= n_info_reload;
        r_info_periodic  <= n_info_periodic;
        r_info_remaining <= n_info_remaining;
        r_info_active    <= n_info_active;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_new_index      = r_new_index;
    assign o_expired_mask   = r_expired;
    assign o_info_reload    = r_info_reload;
    assign o_info_periodic  = r_info_periodic;
    assign o_info_remaining = r_info_remaining;
    assign o_info_active    = r_info_active;
    assign o_tick_count     = r_ticks;

endmodule

>>> rtl/mct_cell.sv
// ----------------------------------------------------------------------------
// mct_cell
// one timer slot: holds its state, updates on commands and passes the link
// word on to its neighbor
// ----------------------------------------------------------------------------
module mct_cell
    import mct_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int IDX         = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_link i_link,
    output t_link o_link
);

    logic                   r_used, r_running, r_mode;
    logic                   n_used, n_running, n_mode;
    logic [COUNT_WIDTH-1:0] r_reload, r_remaining;
    logic [COUNT_WIDTH-1:0] n_reload, n_remaining;

    logic                   hit, sel, free_here, claim, fired;
    logic [COUNT_WIDTH-1:0] dec;
    logic [COUNT_WIDTH+31:0] reload_in_ext, reload_out_ext, remain_out_ext;

    assign hit       = (IDX < 16) && (int'(i_cmd.idx) == IDX);
    assign sel       = hit && r_used;
    assign free_here = i_link.open && !r_used;
    assign claim     = i_cmd.create && free_here;
    assign dec       = r_remaining - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign fired     = i_cmd.tick && r_used && r_running && (dec == '0);

    assign reload_in_ext  = {{COUNT_WIDTH{1'b0}}, i_cmd.reload};
    assign reload_out_ext = {32'd0, r_reload};
    assign remain_out_ext = {32'd0, r_remaining};

    // state update
    always_comb begin
        n_used      = r_used;
        n_running   = r_running;
        n_mode      = r_mode;
        n_reload    = r_reload;
        n_remaining = r_remaining;
        if (i_cmd.tick && r_used && r_running) begin
            n_remaining = dec;
            if (dec == '0) begin
                if (r_mode) begin
                    n_remaining = r_reload;
                end else begin
                    n_running = 1'b0;
                end
            end
        end
        if (claim) begin
            n_used      = 1'b1;
            n_running   = 1'b0;
            n_mode      = i_cmd.periodic;
            n_reload    = reload_in_ext[COUNT_WIDTH-1:0];
            n_remaining = '0;
        end
        if (i_cmd.del && sel) begin
            n_used    = 1'b0;
            n_running = 1'b0;
        end
        if (i_cmd.start && sel) begin
            if (r_remaining == '0) begin
                n_remaining = r_reload;
            end
            n_running = 1'b1;
        end
        if (i_cmd.stop && sel) begin
            n_running = 1'b0;
        end
    end

    // link to the next cell
    always_comb begin
        o_link         = i_link;
        o_link.open    = i_link.open && r_used;
        o_link.expired = i_link.expired | (16'(fired) << IDX);
        if (free_here) begin
            o_link.claim_idx = 4'(IDX);
        end
        if (sel) begin
            o_link.sel_used  = 1'b1;
            o_link.reload    = reload_out_ext[31:0];
            o_link.periodic  = r_mode;
            o_link.remaining = remain_out_ext[31:0];
            o_link.active    = r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_running <= 1'b0;
            r_mode    <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_running <= n_running;
            r_mode    <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reload    <= n_reload;
        r_remaining <= n_remaining;
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the countdown timer bank: command words go in
// through a queued driver, response words are checked against an in-bench
// timer bank model, under several idle and stall mixes plus a long sink
// hold-off
// ----------------------------------------------------------------------------
module tb
    import mct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS        = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          END_CYCLES   = 20;
    localparam int          TIMEOUT_NS   = 4_000_000;
    // opcodes with no operation behind them
    localparam logic [2:0]  OP_UNUSED_LO = 3'd6;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [31:0] reload;
        logic        periodic;
    } t_req_word;

    typedef struct packed {
        t_status     status;
        logic [3:0]  new_index;
        logic [15:0] expired_mask;
        logic [31:0] info_reload;
        logic        info_periodic;
        logic [31:0] info_remaining;
        logic        info_active;
        logic [31:0] tick_count;
    } t_rsp_word;

    // dut ports, inputs all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_opcode      = '0;
    logic [3:0]  i_timer_index = '0;
    logic [31:0] i_reload_tics = '0;
    logic        i_periodic    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_new_index;
    logic [15:0] o_expired_mask;
    logic [31:0] o_info_reload;
    logic        o_info_periodic;
    logic [31:0] o_info_remaining;
    logic        o_info_active;
    logic [31:0] o_tick_count;

    // command words waiting for the driver, responses waiting for the dut
    t_req_word   req_pending[$];
    t_rsp_word   rsp_expected[$];

    // timer bank model state
    logic        bank_used    [SLOTS];
    logic        bank_running [SLOTS];
    logic        bank_periodic[SLOTS];
    logic [31:0] bank_reload  [SLOTS];
    logic [31:0] bank_left    [SLOTS];
    logic [31:0] bank_ticks;

    // allocation shadow kept while generating, so indexes hit live slots
    logic [SLOTS-1:0] gen_used = '0;

    int          mismatch_cnt   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        rx_hold        = 1'b0;
    logic        in_taken       = 1'b0;

    multi_channel_countdown_timer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_timer_index    (i_timer_index),
        .i_reload_tics    (i_reload_tics),
        .i_periodic       (i_periodic),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_new_index      (o_new_index),
        .o_expired_mask   (o_expired_mask),
        .o_info_reload    (o_info_reload),
        .o_info_periodic  (o_info_periodic),
        .o_info_remaining (o_info_remaining),
        .o_info_active    (o_info_active),
        .o_tick_count     (o_tick_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // timer bank model: applies one command word, returns its response
    // ------------------------------------------------------------------
    function automatic t_rsp_word bank_apply(t_req_word w);
        t_rsp_word r;
        logic      hit;
        logic      claimed;
        int        i;
        r       = '0;
        r.status = ST_GOOD;
        hit     = bank_used[w.idx];
        claimed = 1'b0;
        case (w.op)
            OP_TICK: begin
                bank_ticks = bank_ticks + 32'd1;
                for (i = 0; i < SLOTS; i++) begin
                    if (bank_used[i] && bank_running[i]) begin
                        // a count at zero wraps to all ones
                        bank_left[i] = bank_left[i] - 32'd1;
                        if (bank_left[i] == '0) begin
                            if (bank_periodic[i])
                                bank_left[i] = bank_reload[i];
                            else
                                bank_running[i] = 1'b0;
                            r.expired_mask[i] = 1'b1;
                        end
                    end
                end
            end
            OP_CREATE: begin
                r.status = ST_NO_FREE;
                for (i = 0; i < SLOTS; i++) begin
                    if (!claimed && !bank_used[i]) begin
                        claimed          = 1'b1;
                        bank_used[i]     = 1'b1;
                        bank_running[i]  = 1'b0;
                        bank_periodic[i] = w.periodic;
                        bank_reload[i]   = w.reload;
                        bank_left[i]     = '0;
                        r.status         = ST_GOOD;
                        r.new_index      = 4'(i);
                    end
                end
            end
            OP_DELETE: begin
                if (!hit) begin
                    r.status = ST_BAD_ID;
                end else begin
                    bank_used[w.idx]    = 1'b0;
                    bank_running[w.idx] = 1'b0;
                end
            end
            OP_START: begin
                if (!hit) begin
                    r.status = ST_BAD_ID;
                end else begin
                    if (bank_left[w.idx] == '0)
                        bank_left[w.idx] = bank_reload[w.idx];
                    bank_running[w.idx] = 1'b1;
                end
            end
            OP_STOP: begin
                if (!hit)
                    r.status = ST_BAD_ID;
                else
                    bank_running[w.idx] = 1'b0;
            end
            OP_INFO: begin
                if (!hit) begin
                    r.status = ST_BAD_ID;
                end else begin
                    r.info_reload    = bank_reload[w.idx];
                    r.info_periodic  = bank_periodic[w.idx];
                    r.info_remaining = bank_left[w.idx];
                    r.info_active    = bank_running[w.idx];
                end
            end
            default: ;
        endcase
        r.tick_count = bank_ticks;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: checks response words, then books accepted command words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_expected.size() == 0) begin
                $error("response word arrived with nothing expected");
                mismatch_cnt++;
            end else begin
                want = rsp_expected.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("new_index", 32'(want.new_index), 32'(o_new_index));
                check_field("expired_mask", 32'(want.expired_mask),
                            32'(o_expired_mask));
                check_field("info_reload", want.info_reload, o_info_reload);
                check_field("info_periodic", 32'(want.info_periodic),
                            32'(o_info_periodic));
                check_field("info_remaining", want.info_remaining, o_info_remaining);
                check_field("info_active", 32'(want.info_active),
                            32'(o_info_active));
                check_field("tick_count", want.tick_count, o_tick_count);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            rsp_expected.push_back(bank_apply('{i_opcode, i_timer_index,
                                                i_reload_tics, i_periodic}));
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    // ------------------------------------------------------------------
    // driver: a new word only once the previous one was taken, with
    // random idle cycles between words
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w              = req_pending.pop_front();
                i_opcode      <= w.op;
                i_timer_index <= w.idx;
                i_reload_tics <= w.reload;
                i_periodic    <= w.periodic;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // sink side: random stalls, forced low during the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // long sink hold-off, counted here so the sender keeps pushing words
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_word(logic [2:0] op, logic [3:0] idx, logic [31:0] reload,
                              logic periodic);
        req_pending.push_back('{op, idx, reload, periodic});
    endtask

    // mostly short periods so timers expire often, sometimes any value
    function automatic logic [31:0] pick_reload();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 70)
            return 32'($urandom_range(6, 1));
        if (sel < 85)
            return 32'($urandom_range(40, 7));
        return $urandom();
    endfunction

    task automatic queue_random(int count);
        t_req_word w;
        int        sel;
        int        k;
        int        i;
        repeat (count) begin
            sel        = $urandom_range(99);
            w.idx      = 4'($urandom_range(SLOTS - 1));
            w.reload   = $urandom();
            w.periodic = 1'($urandom_range(1));
            if (sel < 35)
                w.op = OP_TICK;
            else if (sel < 49)
                w.op = OP_CREATE;
            else if (sel < 58)
                w.op = OP_DELETE;
            else if (sel < 74)
                w.op = OP_START;
            else if (sel < 81)
                w.op = OP_STOP;
            else if (sel < 97)
                w.op = OP_INFO;
            else
                w.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            if (w.op == OP_CREATE)
                w.reload = pick_reload();
            // slot commands mostly aim at live slots, the rest probe bad ids
            if ((w.op == OP_DELETE || w.op == OP_START || w.op == OP_STOP ||
                 w.op == OP_INFO) && gen_used != '0 && $urandom_range(99) < 85) begin
                k = $urandom_range(SLOTS - 1);
                while (!gen_used[k])
                    k = (k + 1) % SLOTS;
                w.idx = 4'(k);
            end
            if (w.op == OP_CREATE) begin
                k = -1;
                for (i = SLOTS - 1; i >= 0; i--) begin
                    if (!gen_used[i])
                        k = i;
                end
                if (k >= 0)
                    gen_used[k] = 1'b1;
            end else if (w.op == OP_DELETE) begin
                gen_used[w.idx] = 1'b0;
            end
            req_pending.push_back(w);
        end
    endtask

    // wait until every word went in and every response came back
    task automatic wait_drained();
        while (req_pending.size() > 0 || i_in_valid || rsp_expected.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            bank_used[i]     = 1'b0;
            bank_running[i]  = 1'b0;
            bank_periodic[i] = 1'b0;
            bank_reload[i]   = '0;
            bank_left[i]     = '0;
        end
        bank_ticks = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad id, dead opcode, the corner periods, every command
        queue_word(OP_INFO, 4'd0, '0, 1'b0);
        queue_word(OP_UNUSED_HI, 4'd15, 32'hFFFF_FFFF, 1'b1);
        queue_word(OP_CREATE, 4'd9, 32'd0, 1'b1);           // periodic, reload zero
        queue_word(OP_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b0);   // longest period
        queue_word(OP_CREATE, 4'd0, 32'd1, 1'b1);           // fires every tick
        queue_word(OP_CREATE, 4'd0, 32'd2, 1'b0);           // one-shot
        queue_word(OP_START, 4'd0, '0, 1'b0);
        queue_word(OP_START, 4'd2, '0, 1'b0);
        queue_word(OP_START, 4'd3, '0, 1'b0);
        queue_word(OP_TICK, 4'd0, '0, 1'b0);
        queue_word(OP_TICK, 4'd0, '0, 1'b0);
        queue_word(OP_INFO, 4'd0, '0, 1'b0);                // wrapped count
        queue_word(OP_INFO, 4'd3, '0, 1'b0);                // one-shot done
        queue_word(OP_STOP, 4'd2, '0, 1'b0);
        for (i = 4; i < SLOTS; i++)
            queue_word(OP_CREATE, 4'(i), 32'(i), 1'(i % 2));
        queue_word(OP_CREATE, 4'd0, 32'd5, 1'b1);           // bank full
        queue_word(OP_DELETE, 4'd1, '0, 1'b0);
        gen_used = {{(SLOTS - 2){1'b1}}, 2'b01};
        wait_drained();

        // no idling, with the long sink hold-off at the start
        hold_request = 1'b1;
        queue_random(400);
        wait_drained();

        send_idle_pct  = 68;
        recv_stall_pct = 0;
        queue_random(340);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 68;
        queue_random(340);
        wait_drained();

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_random(340);
        wait_drained();

        repeat (END_CYCLES) @(posedge i_clk);
        if (rsp_expected.size() != 0) begin
            $error("%0d response words never arrived", rsp_expected.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
